// ===== src/cau_pkg.sv =====
// shared types and constants for the complex arithmetic unit
package cau_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int WIDE_W        = 64;
   // quotient bits resolved by the divider chain, one per cell
   localparam int QBITS         = 33;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } cau_op_type;

   typedef struct packed {
      cau_op_type        op;
      logic              dz;
      logic              big_re;
      logic              big_im;
      logic              neg_re;
      logic              neg_im;
      logic [WIDE_W-1:0] mag_re;
      logic [WIDE_W-1:0] mag_im;
      logic [WIDE_W-1:0] rem_re;
      logic [WIDE_W-1:0] rem_im;
      logic [WIDE_W-1:0] den;
      logic [QBITS-1:0]  q_re;
      logic [QBITS-1:0]  q_im;
   } cau_stage_type;

   typedef struct packed {
      logic [DATA_W-1:0] res_re;
      logic [DATA_W-1:0] res_im;
      logic              overflow;
      logic              div_by_zero;
   } cau_result_type;

endpackage

// ===== src/cau_front.sv =====
// operand front end: products, sums, magnitudes and divider setup
module cau_front #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  cau_pkg::cau_op_type           in_op,
   input  logic signed [31:0]            a_re,
   input  logic signed [31:0]            a_im,
   input  logic signed [31:0]            b_re,
   input  logic signed [31:0]            b_im,
   output logic                          out_valid,
   output cau_pkg::cau_stage_type        out_stage
);

   // stage a: products and short sums
   logic                va_ff;
   cau_pkg::cau_op_type op_a_ff;
   logic signed [63:0]  p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, sq_r_ff, sq_i_ff;
   logic signed [63:0]  p_rr_in, p_ii_in, p_ri_in, p_ir_in, sq_r_in, sq_i_in;
   logic signed [32:0]  s_re_ff, s_im_ff, s_re_in, s_im_in;

   // stage b: exact signed results and divisor norm
   logic                vb_ff;
   cau_pkg::cau_op_type op_b_ff;
   logic signed [64:0]  val_re_ff, val_im_ff, val_re_in, val_im_in;
   logic [63:0]         den_ff, den_in;

   // stage c: magnitudes, divider start
   logic                   vc_ff;
   cau_pkg::cau_stage_type st_c_ff, st_c_in;
   logic [64:0]            abs_re, abs_im;
   logic [63:0]            rem_re, rem_im;

   assign p_rr_in = 64'(a_re) * 64'(b_re);
   assign p_ii_in = 64'(a_im) * 64'(b_im);
   assign p_ri_in = 64'(a_re) * 64'(b_im);
   assign p_ir_in = 64'(a_im) * 64'(b_re);
   assign sq_r_in = 64'(b_re) * 64'(b_re);
   assign sq_i_in = 64'(b_im) * 64'(b_im);

   always_comb begin
      if (in_op == cau_pkg::OP_SUB) begin
         s_re_in = {a_re[31], a_re} - {b_re[31], b_re};
         s_im_in = {a_im[31], a_im} - {b_im[31], b_im};
      end else begin
         s_re_in = {a_re[31], a_re} + {b_re[31], b_re};
         s_im_in = {a_im[31], a_im} + {b_im[31], b_im};
      end
   end

   always_comb begin
      unique case (op_a_ff)
         cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
            val_re_in = {{32{s_re_ff[32]}}, s_re_ff};
            val_im_in = {{32{s_im_ff[32]}}, s_im_ff};
         end
         cau_pkg::OP_MUL: begin
            val_re_in = {p_rr_ff[63], p_rr_ff} - {p_ii_ff[63], p_ii_ff};
            val_im_in = {p_ri_ff[63], p_ri_ff} + {p_ir_ff[63], p_ir_ff};
         end
         default: begin
            // conjugate product
            val_re_in = {p_rr_ff[63], p_rr_ff} + {p_ii_ff[63], p_ii_ff};
            val_im_in = {p_ir_ff[63], p_ir_ff} - {p_ri_ff[63], p_ri_ff};
         end
      endcase
      den_in = 64'(sq_r_ff) + 64'(sq_i_ff);
   end

   always_comb begin
      abs_re = val_re_ff[64] ? 65'(-val_re_ff) : 65'(val_re_ff);
      abs_im = val_im_ff[64] ? 65'(-val_im_ff) : 65'(val_im_ff);
      rem_re = abs_re[63:0] >> (cau_pkg::QBITS - FRAC_BITS);
      rem_im = abs_im[63:0] >> (cau_pkg::QBITS - FRAC_BITS);
      st_c_in.op     = op_b_ff;
      st_c_in.dz     = (op_b_ff == cau_pkg::OP_DIV) && (den_ff == '0);
      st_c_in.neg_re = val_re_ff[64];
      st_c_in.neg_im = val_im_ff[64];
      if (op_b_ff == cau_pkg::OP_MUL) begin
         st_c_in.mag_re = abs_re[63:0] >> FRAC_BITS;
         st_c_in.mag_im = abs_im[63:0] >> FRAC_BITS;
      end else begin
         st_c_in.mag_re = abs_re[63:0];
         st_c_in.mag_im = abs_im[63:0];
      end
      // quotient needs more bits than the chain resolves: saturates anyway
      st_c_in.big_re = rem_re >= den_ff;
      st_c_in.big_im = rem_im >= den_ff;
      st_c_in.rem_re = rem_re;
      st_c_in.rem_im = rem_im;
      st_c_in.den    = den_ff;
      st_c_in.q_re   = '0;
      st_c_in.q_im   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_a_ff   <= in_op;
         p_rr_ff   <= p_rr_in;
         p_ii_ff   <= p_ii_in;
         p_ri_ff   <= p_ri_in;
         p_ir_ff   <= p_ir_in;
         sq_r_ff   <= sq_r_in;
         sq_i_ff   <= sq_i_in;
         s_re_ff   <= s_re_in;
         s_im_ff   <= s_im_in;
         op_b_ff   <= op_a_ff;
         val_re_ff <= val_re_in;
         val_im_ff <= val_im_in;
         den_ff    <= den_in;
         st_c_ff   <= st_c_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_stage = st_c_ff;

endmodule

// ===== src/cau_div_cell.sv =====
// one restoring divider cell: resolves one quotient bit for both parts
module cau_div_cell #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
   parameter int BIT_POS   = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  cau_pkg::cau_stage_type in_stage,
   output logic                   out_valid,
   output cau_pkg::cau_stage_type out_stage
);

   localparam int NUM_IDX = (BIT_POS >= FRAC_BITS) ? (BIT_POS - FRAC_BITS) : 0;

   logic                   valid_ff;
   cau_pkg::cau_stage_type stage_ff, stage_in;
   logic                   bit_re, bit_im;
   logic [64:0]            sh_re, sh_im;
   logic                   ge_re, ge_im;

   always_comb begin
      // numerator scaled by the fraction: low bits shift in as zero
      bit_re = (BIT_POS >= FRAC_BITS) ? in_stage.mag_re[NUM_IDX] : 1'b0;
      bit_im = (BIT_POS >= FRAC_BITS) ? in_stage.mag_im[NUM_IDX] : 1'b0;
      sh_re  = {in_stage.rem_re, bit_re};
      sh_im  = {in_stage.rem_im, bit_im};
      ge_re  = sh_re >= {1'b0, in_stage.den};
      ge_im  = sh_im >= {1'b0, in_stage.den};
      stage_in        = in_stage;
      stage_in.rem_re = ge_re ? 64'(sh_re - {1'b0, in_stage.den}) : sh_re[63:0];
      stage_in.rem_im = ge_im ? 64'(sh_im - {1'b0, in_stage.den}) : sh_im[63:0];
      stage_in.q_re   = {in_stage.q_re[cau_pkg::QBITS-2:0], ge_re};
      stage_in.q_im   = {in_stage.q_im[cau_pkg::QBITS-2:0], ge_im};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== src/complex_arith_unit.sv =====
// complex add, subtract, multiply and divide on signed fixed point operands
// One word enters per clock and one result word leaves per clock when no stall holds the flow.
// Every operation passes three front stages (products, exact sums, magnitudes), a chain of 33
// divider cells that each settle one quotient bit, and the output register. A result waiting on
// a stalled output goes to a one-word skid register; req_stall rises only while that is full.
module complex_arith_unit #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_a_re,
   input  logic signed [31:0] req_a_im,
   input  logic signed [31:0] req_b_re,
   input  logic signed [31:0] req_b_im,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_res_re,
   output logic signed [31:0] rsp_res_im,
   output logic               rsp_overflow,
   output logic               rsp_div_by_zero
);

   localparam int QB = cau_pkg::QBITS;

   logic                   en;
   logic                   chain_valid [QB+1];
   cau_pkg::cau_stage_type chain_stage [QB+1];

   logic                    out_valid_ff, skid_valid_ff;
   cau_pkg::cau_result_type out_ff, skid_ff, result_in;
   cau_pkg::cau_stage_type  last;
   logic [63:0]             fin_re, fin_im;
   logic                    ovf_re, ovf_im;
   logic [31:0]             sat_re, sat_im;

   function automatic logic [32:0] sat32(input logic neg, input logic [63:0] mag);
      logic [32:0] r;
      if (!neg && mag > 64'h7FFF_FFFF) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (neg && mag > 64'h8000_0000) begin
         r = {1'b1, 32'h8000_0000};
      end else if (neg) begin
         r = {1'b0, 32'(-mag)};
      end else begin
         r = {1'b0, mag[31:0]};
      end
      return r;
   endfunction

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   cau_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_op    (cau_pkg::cau_op_type'(req_type)),
      .a_re     (req_a_re),
      .a_im     (req_a_im),
      .b_re     (req_b_re),
      .b_im     (req_b_im),
      .out_valid(chain_valid[0]),
      .out_stage(chain_stage[0])
   );

   for (genvar j = 0; j < QB; j++) begin : g_cell
      cau_div_cell #(
         .FRAC_BITS(FRAC_BITS),
         .BIT_POS  (QB - 1 - j)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (chain_valid[j]),
         .in_stage (chain_stage[j]),
         .out_valid(chain_valid[j+1]),
         .out_stage(chain_stage[j+1])
      );
   end

   always_comb begin
      last = chain_stage[QB];
      if (last.op == cau_pkg::OP_DIV) begin
         fin_re = last.big_re ? (64'd1 << QB) : 64'(last.q_re);
         fin_im = last.big_im ? (64'd1 << QB) : 64'(last.q_im);
      end else begin
         fin_re = last.mag_re;
         fin_im = last.mag_im;
      end
      {ovf_re, sat_re} = sat32(last.neg_re, fin_re);
      {ovf_im, sat_im} = sat32(last.neg_im, fin_im);
      if (last.dz) begin
         result_in.res_re   = '0;
         result_in.res_im   = '0;
         result_in.overflow = 1'b0;
      end else begin
         result_in.res_re   = sat_re;
         result_in.res_im   = sat_im;
         result_in.overflow = ovf_re | ovf_im;
      end
      result_in.div_by_zero = last.dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!rsp_stall) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (chain_valid[QB]) begin
         if (!out_valid_ff || !rsp_stall) begin
            out_ff       <= result_in;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result_in;
            skid_valid_ff <= 1'b1;
         end
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_res_re      = out_ff.res_re;
   assign rsp_res_im      = out_ff.res_im;
   assign rsp_overflow    = out_ff.overflow;
   assign rsp_div_by_zero = out_ff.div_by_zero;

`ifndef SYNTHESIS
   a_skid_implies_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with empty output register");

   a_dz_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_by_zero) |-> (rsp_res_re == 32'sd0 && rsp_res_im == 32'sd0
                                          && !rsp_overflow))
      else $error("zero divisor result not cleared");

   a_ovf_saturated : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (rsp_res_re == 32'sh7FFF_FFFF
                                       || rsp_res_re == 32'sh8000_0000
                                       || rsp_res_im == 32'sh7FFF_FFFF
                                       || rsp_res_im == 32'sh8000_0000))
      else $error("overflow flagged without a saturated part");
`endif

endmodule

// ===== tb/complex_arith_unit_test.sv =====
// self-checking testbench for the complex arithmetic unit
module complex_arith_unit_test;

   localparam int FRAC      = 16;
   localparam int LATENCY   = 37;
   localparam int IDLE_PCT  = 7;
   localparam int WDOG_MAX  = 2000;
   localparam int N_RANDOM  = 750;

   typedef struct {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic               ovf;
      logic               dz;
   } cplx_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_type;
   logic signed [31:0] req_a_re;
   logic signed [31:0] req_a_im;
   logic signed [31:0] req_b_re;
   logic signed [31:0] req_b_im;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_res_re;
   logic signed [31:0] rsp_res_im;
   logic               rsp_overflow;
   logic               rsp_div_by_zero;

   cplx_result_type pending_results[$];
   int              mismatch_count;
   int              idle_cycles;
   bit              idling_on;
   bit              hold_off_req;
   int              hold_off_len;

   complex_arith_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_a_re(req_a_re), .req_a_im(req_a_im), .req_b_re(req_b_re), .req_b_im(req_b_im),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_res_re(rsp_res_re), .rsp_res_im(rsp_res_im),
      .rsp_overflow(rsp_overflow), .rsp_div_by_zero(rsp_div_by_zero)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // magnitude of (num << FRAC) / den, truncated; anything at 2^63 or above clamps there
   function automatic logic [63:0] scaled_quotient(logic [63:0] num, logic [63:0] den);
      logic [127:0] q;
      q = ({64'd0, num} << FRAC) / {64'd0, den};
      if (q >= (128'd1 << 63))
         return 64'd1 << 63;
      return q[63:0];
   endfunction

   // clamp a signed wide value to 32 bits, flagging saturation
   function automatic logic signed [31:0] clamp32(logic signed [129:0] v, ref logic ovf);
      if (v > 130'sd2147483647) begin
         ovf = 1'b1;
         return 32'sh7FFFFFFF;
      end
      if (v < -130'sd2147483648) begin
         ovf = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // signed value with magnitude truncated by FRAC bits
   function automatic logic signed [129:0] trunc_shift(logic signed [129:0] v);
      logic signed [129:0] m;
      m = (v < 0) ? -v : v;
      m = m >>> FRAC;
      return (v < 0) ? -m : m;
   endfunction

   function automatic logic signed [129:0] div_signed(logic signed [129:0] num,
                                                      logic [63:0] den);
      logic signed [129:0] m;
      logic                neg;
      neg = num < 0;
      m   = neg ? -num : num;
      m   = {66'd0, scaled_quotient(m[63:0], den)};
      return neg ? -m : m;
   endfunction

   function automatic cplx_result_type complex_op(cau_pkg::cau_op_type op,
                                                   logic signed [31:0] ar,
                                                   logic signed [31:0] ai,
                                                   logic signed [31:0] br,
                                                   logic signed [31:0] bi);
      cplx_result_type      r;
      logic signed [129:0]  xr, xi, war, wai, wbr, wbi;
      logic [63:0]          den;
      logic                 ovf;
      war = ar; wai = ai; wbr = br; wbi = bi;
      ovf = 1'b0;
      r.dz = 1'b0;
      case (op)
         cau_pkg::OP_ADD: begin
            xr = war + wbr;
            xi = wai + wbi;
         end
         cau_pkg::OP_SUB: begin
            xr = war - wbr;
            xi = wai - wbi;
         end
         cau_pkg::OP_MUL: begin
            xr = trunc_shift(war * wbr - wai * wbi);
            xi = trunc_shift(war * wbi + wai * wbr);
         end
         default: begin
            den = 64'(wbr * wbr) + 64'(wbi * wbi);
            if (br == 0 && bi == 0) begin
               r.dz = 1'b1;
               xr = 0;
               xi = 0;
            end else begin
               xr = div_signed(war * wbr + wai * wbi, den);
               xi = div_signed(wai * wbr - war * wbi, den);
            end
         end
      endcase
      r.re  = clamp32(xr, ovf);
      r.im  = clamp32(xi, ovf);
      r.ovf = ovf;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic send_word(cau_pkg::cau_op_type op, logic signed [31:0] ar,
                            logic signed [31:0] ai, logic signed [31:0] br,
                            logic signed [31:0] bi);
      while (idling_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= op;
      req_a_re  <= ar;
      req_a_im  <= ai;
      req_b_re  <= br;
      req_b_im  <= bi;
      pending_results.push_back(complex_op(op, ar, ai, br, bi));
      do @(posedge clock); while (req_stall);
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      go_quiet();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_operand();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
         1: return $signed(32'($urandom_range(65536 * 4))) - 32'sd131072;
         2: return $signed($urandom) >>> $urandom_range(31);
         3: return 0;
         default: return $signed($urandom);
      endcase
   endfunction

   task automatic test_directed();
      logic signed [31:0] ext[5];
      ext = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0, 32'sh00010000, 32'shFFFF0000};
      send_word(cau_pkg::OP_ADD, ext[0], ext[1], ext[0], ext[1]);
      send_word(cau_pkg::OP_SUB, ext[1], ext[0], ext[0], ext[1]);
      send_word(cau_pkg::OP_MUL, ext[1], ext[1], ext[1], ext[1]);
      send_word(cau_pkg::OP_MUL, ext[0], ext[1], ext[3], ext[4]);
      send_word(cau_pkg::OP_DIV, ext[0], ext[1], ext[2], ext[2]);
      send_word(cau_pkg::OP_DIV, ext[2], ext[2], ext[2], ext[2]);
      send_word(cau_pkg::OP_DIV, ext[0], ext[0], 32'sd1, 32'sd0);
      send_word(cau_pkg::OP_DIV, ext[1], ext[1], ext[1], ext[1]);
      send_word(cau_pkg::OP_DIV, ext[3], ext[4], ext[3], ext[3]);
      send_word(cau_pkg::OP_DIV, ext[3], ext[3], ext[2], 32'sd1);
      send_word(cau_pkg::OP_DIV, -32'sd7, 32'sd5, 32'sd3, -32'sd2);
      send_word(cau_pkg::OP_MUL, -32'sd3, 32'sd3, 32'sd1, -32'sd1);
      send_word(cau_pkg::OP_ADD, ext[2], ext[2], ext[2], ext[2]);
      send_word(cau_pkg::OP_SUB, ext[2], ext[2], ext[1], ext[1]);
      drain();
   endtask

   task automatic test_random_stream(int n);
      for (int i = 0; i < n; i++)
         send_word(cau_pkg::cau_op_type'($urandom_range(3)), rand_operand(), rand_operand(),
                   rand_operand(), rand_operand());
   endtask

   // receiver holds off long enough to fill the pipe while words keep coming
   task automatic test_backpressure();
      hold_off_len = 120;
      hold_off_req = 1'b1;
      test_random_stream(80);
      drain();
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = cau_pkg::OP_ADD;
      req_a_re       = 0;
      req_a_im       = 0;
      req_b_re       = 0;
      req_b_im       = 0;
      mismatch_count = 0;
      idling_on      = 1'b1;
      hold_off_req   = 1'b0;
      hold_off_len   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_stream(N_RANDOM / 2 - 100);
      drain();
      test_backpressure();
      idling_on = 1'b0;
      test_random_stream(200);
      idling_on = 1'b1;
      test_random_stream(N_RANDOM / 2 - 200);
      drain();
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // result stall: random idling plus the requested long hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (hold_off_len) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= idling_on && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      cplx_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected word", rsp_res_re, 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_res_re !== want.re) report_mismatch("res_re", rsp_res_re, want.re);
            if (rsp_res_im !== want.im) report_mismatch("res_im", rsp_res_im, want.im);
            if (rsp_overflow !== want.ovf)
               report_mismatch("overflow", 32'(rsp_overflow), 32'(want.ovf));
            if (rsp_div_by_zero !== want.dz)
               report_mismatch("div_by_zero", 32'(rsp_div_by_zero), 32'(want.dz));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_MAX) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
